### sv/base_relocation_parser_defines.svh
// ---------------------------------------------------------------------------
// Base relocation parser assertion macros
// Shared concurrent assertion forms for the parser RTL.
// ---------------------------------------------------------------------------
`ifndef BASE_RELOCATION_PARSER_DEFINES_SVH
`define BASE_RELOCATION_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BRP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brp assertion failed");

// next-cycle implication, disabled during reset
`define BRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brp assertion failed");

`endif

### sv/brp_pkg.sv
// ---------------------------------------------------------------------------
// Base relocation parser package
// Types, codes and constants shared by the parser modules.
// ---------------------------------------------------------------------------
package brp_pkg;

   localparam logic [15:0] TypeMask   = 16'hF000;
   localparam logic [15:0] TypeDir64  = 16'hA000;
   localparam logic [15:0] OffsetMask = 16'h0FFF;

   localparam logic [1:0] KindEntry     = 2'd0;
   localparam logic [1:0] KindEnd       = 2'd1;
   localparam logic [1:0] KindBad       = 2'd2;
   localparam logic [1:0] KindExhausted = 2'd3;

   localparam int FifoDepth   = 4;
   localparam int FifoPtrBits = $clog2(FifoDepth);
   localparam int FifoCntBits = $clog2(FifoDepth + 1);

   localparam int CsrAddrBits = 2;
   localparam logic [CsrAddrBits-1:0] CsrAddrDirSize = '0;

   typedef enum logic [5:0] {
      PhPageLo = 6'b000001,
      PhPageHi = 6'b000010,
      PhSizeLo = 6'b000100,
      PhSizeHi = 6'b001000,
      PhEntry  = 6'b010000,
      PhDone   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [15:0] half_word;
      logic        table_start;
      logic        data_final;
   } req_item_type;

   typedef struct packed {
      logic [31:0] target_address;
      logic [1:0]  result_kind;
      logic        run_last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } step_type;

endpackage

### sv/brp_parse_core.sv
// ---------------------------------------------------------------------------
// Base relocation parser core
// Parse state and the combinational step that turns one halfword into up to
// two results.
// ---------------------------------------------------------------------------
`include "base_relocation_parser_defines.svh"

module brp_parse_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  brp_pkg::req_item_type item,
   input  logic [31:0]           directory_size,
   output brp_pkg::step_type     step
);

   brp_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [31:0] page_ff, page_in, page_cur;
   logic [30:0] entries_ff, entries_in, entries_cur, entries_dec;
   logic [31:0] bytes_ff, bytes_in, bytes_cur, bytes_step;
   logic [15:0] hlow_ff, hlow_in, hlow_cur;
   logic [31:0] size_word;
   logic [31:0] entry_addr;
   logic        has_entry;
   logic        has_term;
   logic [1:0]  term_kind;
   brp_pkg::rsp_item_type entry_res, term_res;

   assign size_word   = {item.half_word, hlow_cur};
   assign bytes_step  = (bytes_cur <= 32'hFFFF_FFFD) ? bytes_cur + 32'd2 : 32'hFFFF_FFFF;
   assign entries_dec = entries_cur - 31'd1;
   assign entry_addr  = page_cur + {16'd0, item.half_word & brp_pkg::OffsetMask};

   always_comb begin
      phase_cur   = item.table_start ? brp_pkg::PhPageLo : phase_ff;
      page_cur    = item.table_start ? 32'd0 : page_ff;
      entries_cur = item.table_start ? 31'd0 : entries_ff;
      bytes_cur   = item.table_start ? 32'd0 : bytes_ff;
      hlow_cur    = item.table_start ? 16'd0 : hlow_ff;

      phase_in   = phase_cur;
      page_in    = page_cur;
      entries_in = entries_cur;
      bytes_in   = bytes_cur;
      hlow_in    = hlow_cur;
      has_entry  = 1'b0;
      has_term   = 1'b0;
      term_kind  = brp_pkg::KindEnd;

      if (phase_cur != brp_pkg::PhDone) begin
         if (phase_cur == brp_pkg::PhPageLo && bytes_cur >= directory_size) begin
            has_term = 1'b1;
         end else begin
            bytes_in = bytes_step;
            case (phase_cur)
               brp_pkg::PhPageLo: begin
                  hlow_in  = item.half_word;
                  phase_in = brp_pkg::PhPageHi;
               end
               brp_pkg::PhPageHi: begin
                  page_in  = {item.half_word, hlow_cur};
                  phase_in = brp_pkg::PhSizeLo;
               end
               brp_pkg::PhSizeLo: begin
                  hlow_in  = item.half_word;
                  phase_in = brp_pkg::PhSizeHi;
               end
               brp_pkg::PhSizeHi: begin
                  if (size_word == 32'd0 || page_cur == 32'd0) begin
                     has_term = 1'b1;
                  end else if (size_word[0] || size_word < 32'd8) begin
                     has_term  = 1'b1;
                     term_kind = brp_pkg::KindBad;
                  end else begin
                     entries_in = size_word[31:1] - 31'd4;
                     if (size_word == 32'd8) begin
                        phase_in = brp_pkg::PhPageLo;
                        has_term = (bytes_step >= directory_size);
                     end else begin
                        phase_in = brp_pkg::PhEntry;
                     end
                  end
               end
               brp_pkg::PhEntry: begin
                  has_entry  = ((item.half_word & brp_pkg::TypeMask) == brp_pkg::TypeDir64);
                  entries_in = entries_dec;
                  if (entries_dec == 31'd0) begin
                     phase_in = brp_pkg::PhPageLo;
                     has_term = (bytes_step >= directory_size);
                  end
               end
               default: begin
                  phase_in = brp_pkg::PhDone;
               end
            endcase
         end
         if (!has_term && item.data_final) begin
            has_term  = 1'b1;
            term_kind = brp_pkg::KindExhausted;
         end
         if (has_term) begin
            phase_in = brp_pkg::PhDone;
         end
      end
   end

   always_comb begin
      entry_res.target_address = entry_addr;
      entry_res.result_kind    = brp_pkg::KindEntry;
      entry_res.run_last       = !has_term;
      term_res.target_address  = 32'd0;
      term_res.result_kind     = term_kind;
      term_res.run_last        = 1'b1;
      step.count  = {1'b0, has_entry} + {1'b0, has_term};
      step.first  = has_entry ? entry_res : term_res;
      step.second = term_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= brp_pkg::PhPageLo;
         page_ff    <= '0;
         entries_ff <= '0;
         bytes_ff   <= '0;
         hlow_ff    <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         page_ff    <= page_in;
         entries_ff <= entries_in;
         bytes_ff   <= bytes_in;
         hlow_ff    <= hlow_in;
      end
   end

   `BRP_ASSERT_NEXT(a_end_parks, clock, reset, fire && has_term, phase_ff == brp_pkg::PhDone)
   `BRP_ASSERT_IMPLY(a_done_silent, clock, reset, !item.table_start && phase_ff == brp_pkg::PhDone, step.count == 2'd0)
   `BRP_ASSERT_IMPLY(a_entry_phase, clock, reset, has_entry, phase_cur == brp_pkg::PhEntry)

endmodule

### sv/brp_result_fifo.sv
// ---------------------------------------------------------------------------
// Base relocation parser result queue
// Register queue: takes up to two results a cycle, hands one out unless stalled.
// ---------------------------------------------------------------------------
`include "base_relocation_parser_defines.svh"

module brp_result_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_en,
   input  brp_pkg::step_type     push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output brp_pkg::rsp_item_type rsp_item
);

   brp_pkg::rsp_item_type mem_ff [brp_pkg::FifoDepth];
   logic [brp_pkg::FifoPtrBits-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [brp_pkg::FifoPtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [brp_pkg::FifoCntBits-1:0] count_ff, count_in;
   logic [1:0] push_cnt;
   logic       pop_en;

   assign push_cnt  = push_en ? push.count : 2'd0;
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = mem_ff[rd_ptr_ff];
   assign pop_en    = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= brp_pkg::FifoCntBits'(brp_pkg::FifoDepth - 2));
   assign wr_ptr_nx = wr_ptr_ff + brp_pkg::FifoPtrBits'(1);
   assign wr_ptr_in = wr_ptr_ff + brp_pkg::FifoPtrBits'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + brp_pkg::FifoPtrBits'(pop_en);
   assign count_in  = count_ff + brp_pkg::FifoCntBits'(push_cnt)
                      - brp_pkg::FifoCntBits'(pop_en);

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_nx] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `BRP_ASSERT_IMPLY(a_no_overfill, clock, reset, push_cnt != 2'd0, room)
   `BRP_ASSERT_NEXT(a_count_track, clock, reset, pop_en && push_cnt == 2'd0, count_ff == $past(count_ff) - 1)

endmodule

### sv/base_relocation_parser.sv
// ---------------------------------------------------------------------------
// Base relocation parser
// Parses a relocation table streamed as halfwords and reports 64-bit fixups
// and the reason the table ended.
// ---------------------------------------------------------------------------
// Results: a halfword is held in the input register, then its results are written
//   to the result queue and offered on rsp from there.
// Throughput: one halfword per cycle; the input register waits while the
//   four-entry result queue has fewer than two free slots.
// Reset: synchronous; clears parse state, the queue and directory_size.
// ---------------------------------------------------------------------------
module base_relocation_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  brp_pkg::req_item_type               req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output brp_pkg::rsp_item_type               rsp_item,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [brp_pkg::CsrAddrBits-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   brp_pkg::req_item_type item_ff;
   logic                  in_valid_ff, in_valid_in;
   logic [31:0]           dir_size_ff;
   logic                  accept;
   logic                  advance;
   logic                  room;
   brp_pkg::step_type     step;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == brp_pkg::CsrAddrDirSize) ? dir_size_ff : 32'd0;

   assign advance     = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         dir_size_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == brp_pkg::CsrAddrDirSize) begin
            dir_size_ff <= csr_pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   brp_parse_core u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .item           (item_ff),
      .directory_size (dir_size_ff),
      .step           (step)
   );

   brp_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (advance),
      .push      (step),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
